>>> rtl/n2a_pkg.sv
// shared types, constants and helper functions of the number to ascii formatter
package n2a_pkg;

    localparam int VALUE_W = 24;
    localparam int CHAR_W  = 7;
    localparam int IDX_W   = 3;
    localparam int DIG_W   = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // register index decoded from paddr[2]
    localparam logic REG_NUMBER_FORMAT = 1'b0;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;
    localparam logic [3:0]        NIB_NINE = 4'h9;

    localparam logic [IDX_W-1:0] IDX_LAST_DEC = 3'd7;

    typedef enum logic {
        FMT_HEX = 1'b0,
        FMT_DEC = 1'b1
    } t_fmt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_SCAN,
        ST_DIGIT,
        ST_HEX0,
        ST_HEXX,
        ST_HEXD
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] diff;
        logic               borrow;
    } t_sub_res;

    function automatic logic [VALUE_W-1:0] decade(input logic [IDX_W-1:0] idx);
        logic [VALUE_W-1:0] d;
        unique case (idx)
            3'd0:    d = 24'd10000000;
            3'd1:    d = 24'd1000000;
            3'd2:    d = 24'd100000;
            3'd3:    d = 24'd10000;
            3'd4:    d = 24'd1000;
            3'd5:    d = 24'd100;
            3'd6:    d = 24'd10;
            default: d = 24'd1;
        endcase
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] base;
        base = (nib > NIB_NINE) ? CH_ALPHA : CH_ZERO;
        return base + {3'b000, nib};
    endfunction

endpackage

>>> rtl/n2a_sub.sv
// shared subtract and compare unit against the selected decade
module n2a_sub (
    input  logic [n2a_pkg::VALUE_W-1:0] i_a,
    input  logic [n2a_pkg::IDX_W-1:0]   i_idx,
    output n2a_pkg::t_sub_res           o_res
);
    import n2a_pkg::*;

    logic [VALUE_W:0] w_diff;

    assign w_diff       = {1'b0, i_a} - {1'b0, decade(i_idx)};
    assign o_res.diff   = w_diff[VALUE_W-1:0];
    assign o_res.borrow = w_diff[VALUE_W];

endmodule

>>> rtl/n2a_ctrl.sv
// sequencer that walks decades or nibbles and drives the character register
module n2a_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  n2a_pkg::t_fmt               i_fmt,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [n2a_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [n2a_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last
);
    import n2a_pkg::*;

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [DIG_W-1:0]    r_dig, n_dig;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    t_sub_res            w_sub;
    logic                w_slot;
    logic [4:0]          w_shamt;
    logic [VALUE_W-1:0]  w_shifted;

    n2a_sub u_sub (
        .i_a   (r_val),
        .i_idx (r_idx),
        .o_res (w_sub)
    );

    assign w_slot    = !r_out_valid || !i_out_stall;
    assign w_shamt   = {r_idx, 2'b00};
    assign w_shifted = r_val >> w_shamt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_idx       = r_idx;
        n_dig       = r_dig;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_val = i_value;
                    n_dig = '0;
                    if (i_fmt == FMT_HEX) begin
                        n_state = ST_HEX0;
                        if (i_value[23:16] != 8'h00) begin
                            n_idx = 3'd5;
                        end else if (i_value[15:8] != 8'h00) begin
                            n_idx = 3'd3;
                        end else begin
                            n_idx = 3'd1;
                        end
                    end else if (i_value == '0) begin
                        n_state = ST_ZERO;
                        n_idx   = '0;
                    end else begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                    end
                end
            end
            ST_ZERO: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_ZERO;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // skip leading decades larger than the value
                if (w_sub.borrow) begin
                    n_idx = r_idx + 3'd1;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (!w_sub.borrow) begin
                    n_val = w_sub.diff;
                    n_dig = r_dig + 4'd1;
                end else if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_ZERO + {3'b000, r_dig};
                    n_last      = (r_idx == IDX_LAST_DEC);
                    n_dig       = '0;
                    if (r_idx == IDX_LAST_DEC) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            ST_HEX0: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_ZERO;
                    n_last      = 1'b0;
                    n_state     = ST_HEXX;
                end
            end
            ST_HEXX: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_X;
                    n_last      = 1'b0;
                    n_state     = ST_HEXD;
                end
            end
            ST_HEXD: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = hex_char(w_shifted[3:0]);
                    n_last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

>>> rtl/number_to_ascii_formatter.sv
// top level: apb format register and the character sequencer
// hex emits 0 and x, then one character per nibble; decimal runs on the single shared subtractor
//   (decade scan plus up to nine subtractions and one emit per decade)
// the input is stalled while a value is in work
// reset: synchronous active low, clears control state, format register to decimal
module number_to_ascii_formatter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [n2a_pkg::ADDR_W-1:0]  paddr,
    input  logic [n2a_pkg::DATA_W-1:0]  pwdata,
    output logic [n2a_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // input transaction
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [n2a_pkg::VALUE_W-1:0] i_value,
    // output transaction, one character each
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [n2a_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last
);
    import n2a_pkg::*;

    t_fmt r_fmt, n_fmt;
    logic w_wr;
    logic w_sel_fmt;

    // register index lives in paddr[2], byte lanes below are ignored
    assign w_sel_fmt = (paddr[2] == REG_NUMBER_FORMAT);
    assign w_wr      = psel && penable && pwrite && pready;

    always_comb begin
        n_fmt = r_fmt;
        if (w_wr && w_sel_fmt) begin
            n_fmt = t_fmt'(pwdata[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_DEC;
        end else begin
            r_fmt <= n_fmt;
        end
    end

    // no wait states, reads of unused addresses return zero
    assign pready = 1'b1;
    assign prdata = w_sel_fmt ? {{(DATA_W-1){1'b0}}, r_fmt} : '0;

    // sequencer: decimal by repeated subtraction, hex by nibble select
    n2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt       (r_fmt),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

>>> rtl/n2a_checker.sv
// port level checks of the formatter and their bind to the top level
module n2a_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [n2a_pkg::ADDR_W-1:0]  paddr,
    input  logic [n2a_pkg::DATA_W-1:0]  pwdata,
    input  logic [n2a_pkg::DATA_W-1:0]  prdata,
    input  logic                        pready,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic [n2a_pkg::VALUE_W-1:0] i_value,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [n2a_pkg::CHAR_W-1:0]  o_character,
    input  logic                        o_last
);

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_character) && $stable(o_last))
        else $error("stalled output changed");

    // an accepted value keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // only digits, A to F and x are ever printed
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_character >= 7'h30 && o_character <= 7'h39) ||
                        (o_character >= 7'h41 && o_character <= 7'h46) ||
                        (o_character == 7'h78))
        else $error("unexpected character");

    // while a non-final character is shown the value is still in work
    a_busy_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input ready before the last character");

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (.*);
